FILE: rtl/assert_macros.svh
// assertion macros shared by the search core modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define CITS_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("search core assertion failed");

`define CITS_ASSERT_NEXT(name, cond, later) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (later)) \
    else $error("search core assertion failed");

`else

`define CITS_ASSERT(name, prop)

`define CITS_ASSERT_NEXT(name, cond, later)

`endif

`endif

FILE: rtl/cits_pkg.sv
// types, constants and the character compare for the text search core
`default_nettype none

package cits_pkg;

  localparam int MAX_PATTERN    = 32;
  localparam int REG_SLOTS      = 32;
  localparam int CELLS          = (MAX_PATTERN < REG_SLOTS) ? MAX_PATTERN : REG_SLOTS;
  localparam int BYTES_PER_WORD = 8;
  localparam int PAT_WORDS      = REG_SLOTS / BYTES_PER_WORD;

  localparam int CHAR_W = 8;
  localparam int LINE_W = 12;
  localparam int COL_W  = 8;
  localparam int LEN_W  = 6;
  localparam int CFG_W  = 64;
  localparam int IDX_W  = 3;

  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [LINE_W-1:0] line_t;
  typedef logic [COL_W-1:0]  col_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [IDX_W-1:0]  cfg_index_t;
  typedef logic [CFG_W-1:0]  cfg_data_t;

  localparam cfg_index_t REG_PATTERN_LENGTH  = 3'd0;
  localparam cfg_index_t REG_PATTERN_CHARS_0 = 3'd1;
  localparam cfg_index_t REG_PATTERN_CHARS_1 = 3'd2;
  localparam cfg_index_t REG_PATTERN_CHARS_2 = 3'd3;
  localparam cfg_index_t REG_PATTERN_CHARS_3 = 3'd4;

  localparam char_t CH_LOWER_A = 8'h61;
  localparam char_t CH_LOWER_Z = 8'h7a;
  localparam char_t CH_UPPER_A = 8'h41;
  localparam char_t CH_UPPER_Z = 8'h5a;
  localparam char_t CASE_GAP   = CH_LOWER_A - CH_UPPER_A;

  typedef struct packed {
    logic  empty;
    logic  advance;
    logic  clear;
    char_t text_char;
  } step_t;

  typedef struct packed {
    logic head;
    logic active;
    logic tail;
  } cell_ctl_t;

  typedef struct packed {
    logic  found;
    line_t match_line;
    col_t  match_column;
  } out_item_t;

  function automatic logic char_match(input char_t p, input char_t t);
    logic lower, upper;
    lower = (p >= CH_LOWER_A) && (p <= CH_LOWER_Z);
    upper = (p >= CH_UPPER_A) && (p <= CH_UPPER_Z);
    return (p == t) || (lower && (t == p - CASE_GAP)) || (upper && (t == p + CASE_GAP));
  endfunction

endpackage

`default_nettype wire

FILE: rtl/cits_in_if.sv
// text character channel
`default_nettype none

interface cits_in_if;
  import cits_pkg::*;

  logic  valid;
  logic  ready;
  char_t text_char;
  line_t line_number;
  col_t  column;
  logic  starts_line;
  logic  new_search;
  logic  last_char;

  modport source (
    output valid, text_char, line_number, column, starts_line, new_search, last_char,
    input  ready
  );

  modport sink (
    input  valid, text_char, line_number, column, starts_line, new_search, last_char,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/cits_out_if.sv
// search result channel
`default_nettype none

interface cits_out_if;
  import cits_pkg::*;

  logic  valid;
  logic  ready;
  logic  found;
  line_t match_line;
  col_t  match_column;

  modport source (
    output valid, found, match_line, match_column,
    input  ready
  );

  modport sink (
    input  valid, found, match_line, match_column,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/case_insensitive_text_search_core.sv
// top level of the case-insensitive text search core
// Takes one text character per clock and finds the first place where the configured
// pattern (up to 32 bytes, letters matching in either case) occurs within one line.
// A row of 32 cells, one per pattern position, compares the character against its
// pattern byte and passes its progress bit to the next cell, so every character is
// handled in the cycle it is transferred; the result (found with line and starting
// column, or not found on the last character) is registered into the output buffer.
// A two-entry output buffer lets input keep flowing while a result waits; input
// stalls only when both entries are full. After a result, characters are consumed
// silently until an item marked as a new search. The user must write configuration
// (cfg_we/cfg_index/cfg_data) only while no search is in flight; the core does not check.
`default_nettype none

`include "assert_macros.svh"

module case_insensitive_text_search_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  cits_pkg::cfg_index_t cfg_index,
  input  cits_pkg::cfg_data_t  cfg_data,
  cits_in_if.sink              text_in,
  cits_out_if.source           result_out
);
  import cits_pkg::*;

  len_t      pattern_length;
  cfg_data_t pat_words [PAT_WORDS];
  logic      finished;

  len_t      eff_len;
  len_t      back;
  logic      in_accept;
  logic      room;
  step_t     step;
  logic      match;
  logic      push;
  out_item_t push_item;
  col_t      start_col;

  logic [CELLS-1:0] progress;
  logic [CELLS-1:0] tail_hits;
  logic [CELLS-1:0] tails;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= '0;
      for (int w = 0; w < PAT_WORDS; w++) begin
        pat_words[w] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PATTERN_LENGTH:  pattern_length <= cfg_data[LEN_W-1:0];
        REG_PATTERN_CHARS_0: pat_words[0] <= cfg_data;
        REG_PATTERN_CHARS_1: pat_words[1] <= cfg_data;
        REG_PATTERN_CHARS_2: pat_words[2] <= cfg_data;
        REG_PATTERN_CHARS_3: pat_words[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign eff_len = (pattern_length > LEN_W'(CELLS)) ? LEN_W'(CELLS) : pattern_length;
  assign back    = eff_len - LEN_W'(1);

  assign text_in.ready = room;
  assign in_accept     = text_in.valid & text_in.ready;

  assign step.empty     = (eff_len == '0);
  assign step.advance   = in_accept & (~finished | text_in.new_search);
  assign step.clear     = text_in.starts_line | text_in.new_search;
  assign step.text_char = text_in.text_char;

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    cell_ctl_t ctl;
    logic      left;

    assign ctl.head   = (i == 0);
    assign ctl.active = (LEN_W'(i) < eff_len);
    assign ctl.tail   = (eff_len == LEN_W'(i + 1));
    assign tails[i]   = ctl.tail;

    if (i == 0) begin : g_first
      assign left = 1'b0;
    end else begin : g_rest
      assign left = progress[i-1];
    end

    cits_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .step         (step),
      .ctl          (ctl),
      .pattern_char (pat_words[i / BYTES_PER_WORD][(i % BYTES_PER_WORD) * CHAR_W +: CHAR_W]),
      .left         (left),
      .progress     (progress[i]),
      .tail_hit     (tail_hits[i])
    );
  end

  assign match = |tail_hits;
  assign push  = step.advance & (match | text_in.last_char);

  // starting column saturates at zero
  assign start_col = (text_in.column >= COL_W'(back)) ? text_in.column - COL_W'(back) : '0;

  assign push_item.found        = match;
  assign push_item.match_line   = match ? text_in.line_number : '0;
  assign push_item.match_column = match ? start_col : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      finished <= 1'b0;
    end else if (step.advance) begin
      finished <= match | text_in.last_char;
    end
  end

  cits_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .room       (room),
    .result_out (result_out)
  );

  `CITS_ASSERT(a_silent_after_result, (in_accept && finished && !text_in.new_search) |-> !push)
  `CITS_ASSERT(a_single_tail, $onehot0(tails))
  `CITS_ASSERT_NEXT(a_result_closes_search, push, finished)

endmodule

`default_nettype wire

FILE: rtl/cits_cell.sv
// one pattern position: character compare and shift-and progress bit
`default_nettype none

module cits_cell (
  input  logic              clk,
  input  logic              rst,
  input  cits_pkg::step_t   step,
  input  cits_pkg::cell_ctl_t ctl,
  input  cits_pkg::char_t   pattern_char,
  input  logic              left,
  output logic              progress,
  output logic              tail_hit
);
  import cits_pkg::*;

  logic carry;
  logic hit;
  logic progress_next;

  assign carry         = ctl.head | (left & ~step.clear);
  assign hit           = char_match(pattern_char, step.text_char);
  assign progress_next = carry & hit & ctl.active;
  assign tail_hit      = step.advance & progress_next & ctl.tail;

  always_ff @(posedge clk) begin
    if (rst) begin
      progress <= 1'b0;
    end else if (step.advance) begin
      // empty pattern: progress is only cleared, never shifted
      progress <= step.empty ? (progress & ~step.clear) : progress_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/cits_out_buf.sv
// two-entry result buffer: output register plus skid entry
`default_nettype none

`include "assert_macros.svh"

module cits_out_buf (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  cits_pkg::out_item_t push_item,
  output logic                room,
  cits_out_if.source          result_out
);
  import cits_pkg::*;

  logic      main_valid;
  logic      skid_valid;
  out_item_t main_item;
  out_item_t skid_item;
  logic      pop;

  assign pop   = main_valid & result_out.ready;
  assign room  = ~skid_valid;

  assign result_out.valid        = main_valid;
  assign result_out.found        = main_item.found;
  assign result_out.match_line   = main_item.match_line;
  assign result_out.match_column = main_item.match_column;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        main_item  <= skid_item;
        skid_valid <= push;
        if (push) begin
          skid_item <= push_item;
        end
      end else begin
        main_valid <= push;
        if (push) begin
          main_item <= push_item;
        end
      end
    end else if (push) begin
      if (!main_valid) begin
        main_valid <= 1'b1;
        main_item  <= push_item;
      end else begin
        skid_valid <= 1'b1;
        skid_item  <= push_item;
      end
    end
  end

  `CITS_ASSERT(a_skid_behind_main, skid_valid |-> main_valid)
  `CITS_ASSERT(a_no_push_when_full, !(push && skid_valid))

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
// testbench for the case-insensitive text search core: directed and random searches
`default_nettype none

module tb_top;
  import cits_pkg::*;

  typedef struct packed {
    char_t ch;
    line_t line;
    col_t  col;
    logic  starts;
    logic  fresh;
    logic  last;
  } text_item_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_we;
  cfg_index_t cfg_index;
  cfg_data_t  cfg_data;

  cits_in_if  in_ch ();
  cits_out_if out_ch ();

  case_insensitive_text_search_core dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .text_in    (in_ch),
    .result_out (out_ch)
  );

  always #5 clk = ~clk;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches    = 0;
  int sent_items    = 0;

  logic [LEN_W-1:0]             held_length = '0;
  logic [CELLS*CHAR_W-1:0]      held_chars  = '0;
  logic [CELLS-1:0]             progress    = '0;
  logic                         finished    = 1'b0;
  out_item_t                    expected_reports[$];

  function automatic char_t fold_case(input char_t c);
    return (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? char_t'(c + CASE_GAP) : c;
  endfunction

  function automatic char_t any_case(input char_t c);
    char_t low;
    low = fold_case(c);
    if (low >= CH_LOWER_A && low <= CH_LOWER_Z && $urandom_range(1) == 0)
      return char_t'(low - CASE_GAP);
    return (low >= CH_LOWER_A && low <= CH_LOWER_Z) ? low : c;
  endfunction

  function automatic char_t pattern_byte(input int i);
    return held_chars[CHAR_W*i +: CHAR_W];
  endfunction

  function automatic int active_length();
    return (held_length > CELLS) ? CELLS : int'(held_length);
  endfunction

  function automatic text_item_t make_item(input char_t ch, input line_t line, input col_t col,
                                           input logic starts, input logic fresh,
                                           input logic last);
    text_item_t it;
    it.ch     = ch;
    it.line   = line;
    it.col    = col;
    it.starts = starts;
    it.fresh  = fresh;
    it.last   = last;
    return it;
  endfunction

  function automatic void scan_char(input text_item_t it);
    int               len;
    logic [CELLS-1:0] hits;
    out_item_t        rep;
    sent_items++;
    if (it.fresh) begin
      progress = '0;
      finished = 1'b0;
    end
    if (finished)
      return;
    if (it.starts)
      progress = '0;
    len = active_length();
    if (len > 0) begin
      hits = '0;
      for (int i = 0; i < len; i++)
        hits[i] = (fold_case(pattern_byte(i)) == fold_case(it.ch));
      progress = ((progress << 1) | 1) & hits;
      if (progress[len-1]) begin
        rep.found        = 1'b1;
        rep.match_line   = it.line;
        rep.match_column = (it.col >= len - 1) ? col_t'(it.col - (len - 1)) : '0;
        expected_reports.push_back(rep);
        finished = 1'b1;
        return;
      end
    end
    if (it.last) begin
      rep = '0;
      expected_reports.push_back(rep);
      finished = 1'b1;
    end
  endfunction

  task automatic send_item(input text_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.text_char   <= it.ch;
    in_ch.line_number <= it.line;
    in_ch.column      <= it.col;
    in_ch.starts_line <= it.starts;
    in_ch.new_search  <= it.fresh;
    in_ch.last_char   <= it.last;
    do @(posedge clk); while (!in_ch.ready);
    scan_char(it);
  endtask

  task automatic send_line(input string s, input line_t line, input col_t col0,
                           input logic starts, input logic fresh, input logic last);
    for (int k = 0; k < s.len(); k++)
      send_item(make_item(s[k], line, col_t'(col0 + k), starts && k == 0, fresh && k == 0,
                          last && k == s.len() - 1));
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (expected_reports.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_pattern(input logic [LEN_W-1:0] len,
                               input logic [CELLS*CHAR_W-1:0] chars);
    cfg_index_t regs[5];
    regs = '{REG_PATTERN_LENGTH, REG_PATTERN_CHARS_0, REG_PATTERN_CHARS_1,
             REG_PATTERN_CHARS_2, REG_PATTERN_CHARS_3};
    for (int r = 0; r < 5; r++) begin
      cfg_we    <= 1'b1;
      cfg_index <= regs[r];
      cfg_data  <= (r == 0) ? cfg_data_t'(len) : chars[CFG_W*(r-1) +: CFG_W];
      @(posedge clk);
    end
    cfg_we      <= 1'b0;
    held_length = len;
    held_chars  = chars;
  endtask

  task automatic pick_pattern();
    logic [LEN_W-1:0]        len;
    logic [CELLS*CHAR_W-1:0] chars;
    char_t                   b;
    case ($urandom_range(9))
      0:       len = '0;
      1:       len = LEN_W'(CELLS);
      2:       len = LEN_W'($urandom_range(CELLS + 1, 63));
      default: len = LEN_W'($urandom_range(1, 8));
    endcase
    for (int k = 0; k < CELLS; k++) begin
      case ($urandom_range(9))
        0:          b = '0;
        1, 2, 3:    b = char_t'($urandom);
        default:    b = any_case(char_t'(CH_LOWER_A + $urandom_range(3)));
      endcase
      chars[CHAR_W*k +: CHAR_W] = b;
    end
    write_pattern(len, chars);
  endtask

  task automatic run_clean_search();
    int         plen;
    int         nlines;
    int         line_len;
    logic       end_mark;
    line_t      line;
    col_t       col0;
    char_t      text[$];
    plen     = active_length();
    nlines   = $urandom_range(1, 4);
    line     = line_t'($urandom);
    col0     = col_t'($urandom);
    end_mark = ($urandom_range(9) != 0);
    for (int n = 0; n < nlines; n++) begin
      line_len = (plen > 8 && $urandom_range(1)) ? plen + $urandom_range(0, 6)
                                                 : $urandom_range(1, 12);
      text.delete();
      while (text.size() < line_len) begin
        if (plen > 0 && $urandom_range(5) == 0 && text.size() + plen <= line_len) begin
          for (int k = 0; k < plen; k++)
            text.push_back(any_case(pattern_byte(k)));
        end else if ($urandom_range(1)) begin
          text.push_back(any_case(pattern_byte($urandom_range(0, plen > 0 ? plen - 1 : 0))));
        end else begin
          text.push_back(char_t'($urandom));
        end
      end
      for (int k = 0; k < text.size(); k++)
        send_item(make_item(text[k], line, (n == 0) ? col_t'(col0 + k) : col_t'(k),
                            k == 0, n == 0 && k == 0,
                            end_mark && n == nlines - 1 && k == text.size() - 1));
      line++;
    end
  endtask

  task automatic run_broken_search();
    text_item_t it;
    int         count;
    count = $urandom_range(3, 20);
    for (int k = 0; k < count; k++) begin
      it = text_item_t'($urandom);
      if ($urandom_range(1))
        it.ch = any_case(pattern_byte($urandom_range(0, CELLS - 1)));
      it.fresh = (k == 0) || ($urandom_range(7) == 0);
      send_item(it);
    end
  endtask

  task automatic test_empty_pattern();
    send_item(make_item(8'hFF, 12'hFFF, 8'hFF, 1'b1, 1'b1, 1'b1));
    drain_results();
    write_pattern('0, '1);
    send_item(make_item(8'h00, 12'h000, 8'h00, 1'b1, 1'b1, 1'b1));
  endtask

  task automatic test_mixed_case();
    drain_results();
    write_pattern(LEN_W'(3), 256'h314261);
    send_line("xAb1", 12'd7, 8'd3, 1'b1, 1'b1, 1'b1);
    send_line("ab1", 12'd7, 8'd7, 1'b0, 1'b0, 1'b0);
  endtask

  task automatic test_line_boundary();
    send_line("aB", 12'd1, 8'd0, 1'b1, 1'b1, 1'b0);
    send_line("1", 12'd2, 8'd0, 1'b1, 1'b0, 1'b1);
  endtask

  task automatic test_column_wrap();
    send_line("Ab1", 12'hFFF, 8'hFF, 1'b1, 1'b1, 1'b0);
  endtask

  task automatic test_zero_byte();
    drain_results();
    write_pattern(LEN_W'(2), 256'h6100);
    send_item(make_item(8'h20, 12'd5, 8'd0, 1'b1, 1'b1, 1'b0));
    send_item(make_item(CH_LOWER_A, 12'd5, 8'd1, 1'b0, 1'b0, 1'b0));
    send_item(make_item(8'h00, 12'd5, 8'd2, 1'b0, 1'b0, 1'b0));
    send_item(make_item(CH_UPPER_A, 12'd5, 8'd3, 1'b0, 1'b0, 1'b1));
  endtask

  task automatic test_long_length();
    drain_results();
    write_pattern(LEN_W'(63), {CELLS{CH_LOWER_Z}});
    send_line("ZzZz", 12'd9, 8'd0, 1'b1, 1'b1, 1'b1);
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct, input int target);
    int goal;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    goal          = sent_items + target;
    drain_results();
    pick_pattern();
    while (sent_items < goal) begin
      if ($urandom_range(2) == 0) begin
        drain_results();
        pick_pattern();
      end
      if ($urandom_range(4) == 0)
        run_broken_search();
      else
        run_clean_search();
    end
  endtask

  always @(posedge clk) begin : result_check
    out_item_t got;
    out_item_t want;
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    if (!rst && out_ch.valid && out_ch.ready) begin
      got.found        = out_ch.found;
      got.match_line   = out_ch.match_line;
      got.match_column = out_ch.match_column;
      if (expected_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: found=%0d line=%0d column=%0d",
                   got.found, got.match_line, got.match_column);
      end else begin
        want = expected_reports.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected found=%0d line=%0d column=%0d",
                     want.found, want.match_line, want.match_column,
                     ", got found=%0d line=%0d column=%0d",
                     got.found, got.match_line, got.match_column);
        end
      end
    end
  end

  initial begin
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_index          = REG_PATTERN_LENGTH;
    cfg_data           = '0;
    in_ch.valid        = 1'b0;
    in_ch.text_char    = '0;
    in_ch.line_number  = '0;
    in_ch.column       = '0;
    in_ch.starts_line  = 1'b0;
    in_ch.new_search   = 1'b0;
    in_ch.last_char    = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 32;
    recv_idle_pct = 71;
    test_empty_pattern();
    test_mixed_case();
    test_line_boundary();
    test_column_wrap();
    test_zero_byte();
    test_long_length();

    test_random_traffic(32, 71, 345);
    test_random_traffic(71, 32, 345);
    test_random_traffic(0, 0, 345);

    drain_results();
    if (mismatches == 0 && expected_reports.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  initial begin
    #5000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire
